// ===== sv/ir_pulse_distance_frame_encoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Pulse-distance infrared frame encoder: assertion macros
// Shared property templates, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_FRAME_ENCODER_UNIT_DEFINES_SVH
`define IR_PULSE_DISTANCE_FRAME_ENCODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRPDFE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IRPDFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/irpdfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse-distance infrared frame encoder: package
// Pulse timings, sequencer step limits and the command word passed from the
// front end to the pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package irpdfe_pkg;

	localparam int FuncW   = 2;
	localparam int FrameW  = 28;
	localparam int DurW    = 17;
	localparam int StepW   = 6;

	localparam logic [FuncW-1:0] FuncFrame     = 2'd0;
	localparam logic [FuncW-1:0] FuncRaw       = 2'd1;
	localparam logic [FuncW-1:0] FuncRepeat    = 2'd2;
	localparam logic [FuncW-1:0] FuncGapRepeat = 2'd3;

	localparam logic [DurW-1:0] HdrMark      = 17'd8960;
	localparam logic [DurW-1:0] HdrSpace     = 17'd4480;
	localparam logic [DurW-1:0] AltHdrMark   = 17'd3000;
	localparam logic [DurW-1:0] AltHdrSpace  = 17'd9500;
	localparam logic [DurW-1:0] BitMark      = 17'd560;
	localparam logic [DurW-1:0] OneSpace     = 17'd1680;
	localparam logic [DurW-1:0] ZeroSpace    = 17'd560;
	localparam logic [DurW-1:0] RepHdrSpace  = 17'd2240;
	localparam logic [DurW-1:0] FirstGap     = 17'd52000;
	localparam logic [DurW-1:0] LaterGap     = 17'd98240;

	localparam logic [StepW-1:0] FrameLastStep  = 6'd58;
	localparam logic [StepW-1:0] RepLastStep    = 6'd3;
	localparam logic [StepW-1:0] RepNoGapStart  = 6'd1;
	localparam logic [StepW-1:0] FirstBitSpace  = 6'd3;

	typedef struct packed {
		logic              is_frame;
		logic              gap;
		logic              gap_long;
		logic              alt;
		logic [FrameW-1:0] data;
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/irpdfe_front.sv =====
// ----------------------------------------------------------------------------
// Pulse-distance infrared frame encoder: front end
// Accepts requests, builds the 28-bit frame word with its checksum, chooses
// the gap length and writes one command word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module irpdfe_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire logic                            q_full,
	input  wire logic [irpdfe_pkg::FuncW-1:0]    func,
	input  wire logic [7:0]                      address,
	input  wire logic [15:0]                     command,
	input  wire logic [irpdfe_pkg::FrameW-1:0]   raw_data,
	input  wire logic                            alt_header,
	output logic                                 q_wr,
	output irpdfe_pkg::cmd_t                     q_cmd
);

	logic       rep_sent_q;
	logic [3:0] checksum;

	assign q_wr = push && !q_full;
	assign checksum = command[3:0] + command[7:4] + command[11:8] + command[15:12];

	always_comb begin
		q_cmd          = '0;
		q_cmd.alt      = alt_header;
		q_cmd.gap_long = rep_sent_q;
		case (func)
			irpdfe_pkg::FuncFrame: begin
				q_cmd.is_frame = 1'b1;
				q_cmd.data     = {address, command, checksum};
			end
			irpdfe_pkg::FuncRaw: begin
				q_cmd.is_frame = 1'b1;
				q_cmd.data     = raw_data;
			end
			irpdfe_pkg::FuncGapRepeat: begin
				q_cmd.gap = 1'b1;
			end
			default: begin
				q_cmd.gap = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_sent_q <= 1'b0;
		end else if (q_wr) begin
			if (func == irpdfe_pkg::FuncFrame || func == irpdfe_pkg::FuncRaw) begin
				rep_sent_q <= 1'b0;
			end else if (func == irpdfe_pkg::FuncGapRepeat) begin
				rep_sent_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/irpdfe_queue.sv =====
// ----------------------------------------------------------------------------
// Pulse-distance infrared frame encoder: command queue
// A short first-in first-out store of command words between the front end
// and the pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module irpdfe_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire irpdfe_pkg::cmd_t  wr_cmd,
	input  wire logic              rd,
	output logic                   full,
	output logic                   has_item,
	output irpdfe_pkg::cmd_t       head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	irpdfe_pkg::cmd_t    store_q [DEPTH];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;

	assign full     = (count_q == CntW'(DEPTH));
	assign has_item = (count_q != '0);
	assign head     = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/irpdfe_back.sv =====
// ----------------------------------------------------------------------------
// Pulse-distance infrared frame encoder: pulse sequencer
// Steps through the pulses of one command, one pulse per cycle unless held,
// into an output register, and takes the next command as the last pulse leaves.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ir_pulse_distance_frame_encoder_unit_defines.svh"

module irpdfe_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_has_item,
	input  wire irpdfe_pkg::cmd_t               q_head,
	output logic                                q_rd,
	input  wire logic                           pop,
	output logic                                empty,
	output logic                                level,
	output logic [irpdfe_pkg::DurW-1:0]         duration_us,
	output logic                                last
);

	irpdfe_pkg::cmd_t                    cmd_q;
	logic [irpdfe_pkg::FrameW-1:0]       data_q;
	logic [irpdfe_pkg::StepW-1:0]        step_q;
	logic                                busy_q;
	logic                                ovalid_q;
	logic                                level_q;
	logic [irpdfe_pkg::DurW-1:0]         dur_q;
	logic                                last_q;

	logic                                out_taken;
	logic                                advance;
	logic                                final_step;
	logic                                load;
	logic                                p_level;
	logic [irpdfe_pkg::DurW-1:0]         p_dur;

	assign out_taken  = pop && ovalid_q;
	assign advance    = busy_q && (!ovalid_q || out_taken);
	assign final_step = cmd_q.is_frame ? (step_q == irpdfe_pkg::FrameLastStep)
	                                   : (step_q == irpdfe_pkg::RepLastStep);
	assign load       = !busy_q || (advance && final_step);
	assign q_rd       = load && q_has_item;

	always_comb begin
		p_level = 1'b0;
		p_dur   = irpdfe_pkg::BitMark;
		if (cmd_q.is_frame) begin
			p_level = !step_q[0];
			if (step_q == '0) begin
				p_dur = cmd_q.alt ? irpdfe_pkg::AltHdrMark : irpdfe_pkg::HdrMark;
			end else if (step_q == irpdfe_pkg::StepW'(1)) begin
				p_dur = cmd_q.alt ? irpdfe_pkg::AltHdrSpace : irpdfe_pkg::HdrSpace;
			end else if (step_q[0]) begin
				p_dur = data_q[irpdfe_pkg::FrameW-1] ? irpdfe_pkg::OneSpace
				                                     : irpdfe_pkg::ZeroSpace;
			end
		end else begin
			p_level = step_q[0];
			case (step_q[1:0])
				2'd0:    p_dur = cmd_q.gap_long ? irpdfe_pkg::LaterGap : irpdfe_pkg::FirstGap;
				2'd1:    p_dur = cmd_q.alt ? irpdfe_pkg::AltHdrMark : irpdfe_pkg::HdrMark;
				2'd2:    p_dur = irpdfe_pkg::RepHdrSpace;
				default: p_dur = irpdfe_pkg::BitMark;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
			step_q   <= '0;
		end else begin
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (out_taken) begin
				ovalid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= q_has_item;
				if (q_head.is_frame || q_head.gap) begin
					step_q <= '0;
				end else begin
					step_q <= irpdfe_pkg::RepNoGapStart;
				end
			end else if (advance) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cmd_q  <= q_head;
			data_q <= q_head.data;
		end else if (advance && cmd_q.is_frame && step_q[0] &&
		             step_q >= irpdfe_pkg::FirstBitSpace) begin
			data_q <= {data_q[irpdfe_pkg::FrameW-2:0], 1'b0};
		end
		if (advance) begin
			level_q <= p_level;
			dur_q   <= p_dur;
			last_q  <= final_step;
		end
	end

	assign empty       = !ovalid_q;
	assign level       = level_q;
	assign duration_us = dur_q;
	assign last        = last_q;

	`IRPDFE_ASSERT_SAME(a_frame_step_range, busy_q && cmd_q.is_frame, step_q <= irpdfe_pkg::FrameLastStep, "frame step beyond stop mark")
	`IRPDFE_ASSERT_SAME(a_rep_step_range, busy_q && !cmd_q.is_frame, step_q <= irpdfe_pkg::RepLastStep, "repeat step beyond final mark")
	`IRPDFE_ASSERT_NEXT(a_stall_holds_step, busy_q && ovalid_q && !pop, $stable(step_q) && busy_q, "sequencer moved while output stalled")
	`IRPDFE_ASSERT_NEXT(a_idle_after_last, advance && final_step && !q_has_item, !busy_q && last_q, "sequencer did not stop after last pulse")

endmodule

`default_nettype wire

// ===== sv/ir_pulse_distance_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// Pulse-distance infrared frame encoder
// Turns frame and repeat requests into mark/space pulse lengths in
// microseconds for a 28-bit pulse-distance infrared protocol.
//
//   Channel   Handshake     Beat contents
//   request   push / full   func, address, command, raw_data, alt_header
//   pulse     pop / empty   level, duration_us, last
//
// A data or raw frame gives 59 pulse beats, a repeat 3 and a repeat after gap 4.
// The pulse sequencer issues one pulse per cycle while its output is not held;
// requests queue up in front of it while it is busy, up to QUEUE_DEPTH.
// An accepted request passes the queue and the sequencer's command register first.
// Reset clears the queue, the sequencer and the repeat history at once.
// A held pulse stalls the sequencer; a full queue stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_frame_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [irpdfe_pkg::FuncW-1:0]    func,
	input  wire logic [7:0]                      address,
	input  wire logic [15:0]                     command,
	input  wire logic [irpdfe_pkg::FrameW-1:0]   raw_data,
	input  wire logic                            alt_header,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic                                 level,
	output logic [irpdfe_pkg::DurW-1:0]          duration_us,
	output logic                                 last
);

	logic             q_wr;
	logic             q_rd;
	logic             q_has_item;
	irpdfe_pkg::cmd_t wr_cmd;
	irpdfe_pkg::cmd_t head;

	irpdfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.q_full     (full),
		.func       (func),
		.address    (address),
		.command    (command),
		.raw_data   (raw_data),
		.alt_header (alt_header),
		.q_wr       (q_wr),
		.q_cmd      (wr_cmd)
	);

	irpdfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_cmd   (wr_cmd),
		.rd       (q_rd),
		.full     (full),
		.has_item (q_has_item),
		.head     (head)
	);

	irpdfe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_has_item  (q_has_item),
		.q_head      (head),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.level       (level),
		.duration_us (duration_us),
		.last        (last)
	);

endmodule

`default_nettype wire
